### rtl/core/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared widths, symbol codes and the decimal digit word for the Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int unsigned VALUE_W = 12;
    localparam int unsigned CODE_W  = 5;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned THOU_W  = 2;
    localparam int unsigned REP_W   = 2;

    localparam logic [VALUE_W-1:0] MAX_VALID = VALUE_W'(3999);

    // Symbol codes: index into the greedy table M, CM, D, ... , I
    localparam logic [CODE_W-1:0] SYM_M  = CODE_W'(0);
    localparam logic [CODE_W-1:0] SYM_CM = CODE_W'(1);
    localparam logic [CODE_W-1:0] SYM_XC = CODE_W'(5);
    // units glyph for digit d (1..9) has code UNIT_BASE - d
    localparam logic [CODE_W-1:0] UNIT_BASE = CODE_W'(18);

    // Decimal digits of one value, plus the out-of-range mark
    typedef struct packed {
        logic               oor;
        logic [THOU_W-1:0]  th;
        logic [DIGIT_W-1:0] hu;
        logic [DIGIT_W-1:0] te;
        logic [DIGIT_W-1:0] un;
    } digits_t;

endpackage

### rtl/core/rne_digit_pipe.sv
// ----------------------------------------------------------------------------
// rne_digit_pipe
// Three-stage pipeline that splits a value into thousands, hundreds, tens
// and units digits; each stage holds while the next one cannot take its word.
// ----------------------------------------------------------------------------
module rne_digit_pipe
    import rne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [VALUE_W-1:0] in_value,
    output logic               in_ready,
    output logic               out_valid,
    output digits_t            out_digits,
    input  logic               out_take
);

    localparam int unsigned REM1_W = 10;  // remainder below 1000
    localparam int unsigned REM2_W = 7;   // remainder below 100

    // Stage 1: thousands
    logic               s1_valid_reg;
    logic               s1_oor_reg;
    logic [THOU_W-1:0]  s1_th_reg;
    logic [REM1_W-1:0]  s1_rem_reg;
    // Stage 2: hundreds
    logic               s2_valid_reg;
    logic               s2_oor_reg;
    logic [THOU_W-1:0]  s2_th_reg;
    logic [DIGIT_W-1:0] s2_hu_reg;
    logic [REM2_W-1:0]  s2_rem_reg;
    // Stage 3: tens and units
    logic               s3_valid_reg;
    digits_t            s3_digits_reg;

    logic               s1_free;
    logic               s2_free;
    logic               s3_free;

    logic [THOU_W-1:0]  s1_th_next;
    logic [VALUE_W-1:0] s1_sub;
    logic [DIGIT_W-1:0] s2_hu_next;
    logic [REM1_W-1:0]  s2_sub;
    logic [DIGIT_W-1:0] s3_te_next;
    logic [REM2_W-1:0]  s3_sub;

    assign s3_free  = !s3_valid_reg || out_take;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    assign out_valid  = s3_valid_reg;
    assign out_digits = s3_digits_reg;

    always_comb
    begin
        priority if (in_value >= VALUE_W'(3000))
        begin
            s1_th_next = THOU_W'(3);
        end
        else if (in_value >= VALUE_W'(2000))
        begin
            s1_th_next = THOU_W'(2);
        end
        else if (in_value >= VALUE_W'(1000))
        begin
            s1_th_next = THOU_W'(1);
        end
        else
        begin
            s1_th_next = THOU_W'(0);
        end
        s1_sub = in_value - VALUE_W'(s1_th_next) * VALUE_W'(1000);
    end

    always_comb
    begin
        s2_hu_next = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s1_rem_reg >= REM1_W'(k * 100))
            begin
                s2_hu_next = DIGIT_W'(k);
            end
        end
        s2_sub = s1_rem_reg - REM1_W'(s2_hu_next) * REM1_W'(100);
    end

    always_comb
    begin
        s3_te_next = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s2_rem_reg >= REM2_W'(k * 10))
            begin
                s3_te_next = DIGIT_W'(k);
            end
        end
        s3_sub = s2_rem_reg - REM2_W'(s3_te_next) * REM2_W'(10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_oor_reg <= (in_value > MAX_VALID);
            s1_th_reg  <= s1_th_next;
            s1_rem_reg <= s1_sub[REM1_W-1:0];
        end
        if (s2_free)
        begin
            s2_oor_reg <= s1_oor_reg;
            s2_th_reg  <= s1_th_reg;
            s2_hu_reg  <= s2_hu_next;
            s2_rem_reg <= s2_sub[REM2_W-1:0];
        end
        if (s3_free)
        begin
            s3_digits_reg.oor <= s2_oor_reg;
            s3_digits_reg.th  <= s2_th_reg;
            s3_digits_reg.hu  <= s2_hu_reg;
            s3_digits_reg.te  <= s3_te_next;
            s3_digits_reg.un  <= s3_sub[DIGIT_W-1:0];
        end
    end

endmodule

### rtl/core/rne_token_seq.sv
// ----------------------------------------------------------------------------
// rne_token_seq
// Token sequencer: takes one digit word and emits its symbol tokens one per
// cycle through a registered output.
// ----------------------------------------------------------------------------
module rne_token_seq
    import rne_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  digits_t           in_digits,
    output logic              in_take,
    output logic              tok_valid,
    output logic [CODE_W-1:0] tok_code,
    output logic              tok_oor,
    output logic              tok_last
);

    // One decimal group: optional leading symbol, then repeats of one symbol
    typedef struct packed {
        logic              lead_v;
        logic [CODE_W-1:0] lead_code;
        logic [REP_W-1:0]  rep;
    } group_t;

    typedef struct packed {
        logic              oor;
        logic [THOU_W-1:0] th;
        group_t            hu;
        group_t            te;
        logic              un_v;
        logic [CODE_W-1:0] un_code;
    } pend_t;

    localparam logic [CODE_W-1:0] HU_BASE = SYM_CM;
    localparam logic [CODE_W-1:0] TE_BASE = SYM_XC;

    pend_t             pend_reg;
    pend_t             pend_next;
    pend_t             cur;
    logic              active_reg;
    logic              active_next;
    logic              remain;
    logic              emit_v;
    logic [CODE_W-1:0] emit_code;
    logic              emit_oor;

    logic              valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              oor_reg;
    logic              last_reg;

    // Leading symbol sits at base (9), base+1 (5..8) or base+2 (4);
    // the repeated symbol is base+3
    function automatic group_t split_group(input logic [DIGIT_W-1:0] d,
                                           input logic [CODE_W-1:0]  base);
        group_t g;
        g = '0;
        unique case (d)
            DIGIT_W'(9):
            begin
                g.lead_v    = 1'b1;
                g.lead_code = base;
            end
            DIGIT_W'(5), DIGIT_W'(6), DIGIT_W'(7), DIGIT_W'(8):
            begin
                g.lead_v    = 1'b1;
                g.lead_code = base + CODE_W'(1);
                g.rep       = REP_W'(d - DIGIT_W'(5));
            end
            DIGIT_W'(4):
            begin
                g.lead_v    = 1'b1;
                g.lead_code = base + CODE_W'(2);
            end
            DIGIT_W'(1), DIGIT_W'(2), DIGIT_W'(3):
            begin
                g.rep = d[REP_W-1:0];
            end
            default:
            begin
                g = '0;
            end
        endcase
        return g;
    endfunction

    // Consume the highest pending token
    always_comb
    begin
        cur       = pend_reg;
        emit_v    = active_reg;
        emit_code = SYM_M;
        emit_oor  = 1'b0;
        if (active_reg)
        begin
            priority if (cur.oor)
            begin
                emit_oor = 1'b1;
                cur.oor  = 1'b0;
            end
            else if (cur.th != '0)
            begin
                emit_code = SYM_M;
                cur.th    = cur.th - THOU_W'(1);
            end
            else if (cur.hu.lead_v)
            begin
                emit_code     = cur.hu.lead_code;
                cur.hu.lead_v = 1'b0;
            end
            else if (cur.hu.rep != '0)
            begin
                emit_code  = HU_BASE + CODE_W'(3);
                cur.hu.rep = cur.hu.rep - REP_W'(1);
            end
            else if (cur.te.lead_v)
            begin
                emit_code     = cur.te.lead_code;
                cur.te.lead_v = 1'b0;
            end
            else if (cur.te.rep != '0)
            begin
                emit_code  = TE_BASE + CODE_W'(3);
                cur.te.rep = cur.te.rep - REP_W'(1);
            end
            else
            begin
                emit_code = cur.un_code;
                cur.un_v  = 1'b0;
            end
        end
    end

    assign remain = cur.oor || (cur.th != '0) || cur.hu.lead_v || (cur.hu.rep != '0)
                 || cur.te.lead_v || (cur.te.rep != '0) || cur.un_v;

    assign in_take = !active_reg || !remain;

    // Load a new word as the current run ends, else advance the run
    always_comb
    begin
        pend_next   = cur;
        active_next = active_reg;
        if (in_take)
        begin
            active_next = in_valid;
            if (in_valid)
            begin
                pend_next = '0;
                if (in_digits.oor)
                begin
                    pend_next.oor = 1'b1;
                end
                else
                begin
                    pend_next.th      = in_digits.th;
                    pend_next.hu      = split_group(in_digits.hu, HU_BASE);
                    pend_next.te      = split_group(in_digits.te, TE_BASE);
                    pend_next.un_v    = (in_digits.un != '0);
                    pend_next.un_code = UNIT_BASE - CODE_W'(in_digits.un);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= emit_v;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        code_reg <= emit_code;
        oor_reg  <= emit_oor;
        last_reg <= !remain;
    end

    assign tok_valid = valid_reg;
    assign tok_code  = code_reg;
    assign tok_oor   = oor_reg;
    assign tok_last  = last_reg;

endmodule

### rtl/core/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 12-bit unsigned value into its Roman numeral as a run of symbol
// tokens, one token per cycle.
// ----------------------------------------------------------------------------
//
//   channel   handshake           word fields
//   -------   -----------------   ------------------------------------
//   command   start / busy        value[11:0]
//   result    valid (strobe)      symbol_code[4:0], out_of_range, last
//
// A word is taken at a clock edge with start high and busy low. Three
// pipeline stages split it into digits (thousands, hundreds, tens/units);
// the token sequencer then emits one token per cycle, so a value yields
// 1 to 12 tokens (12 for 3888); that sequencer sets the sustained rate.
// The first token passes the digit stages, then the pending and output registers.
// A zero value produces no tokens; a value above 3999 produces one token
// flagged out of range. Reset clears all valid bits and the sequencer.
// The result side cannot stall: each token is on the ports for exactly one
// cycle. Back-pressure from the sequencer holds the digit stages and
// finally raises busy.
//
module roman_numeral_encoder
    import rne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    output logic               valid,
    output logic [CODE_W-1:0]  symbol_code,
    output logic               out_of_range,
    output logic               last
);

    logic    pipe_ready;
    logic    digits_valid;
    digits_t digits;
    logic    digits_take;

    assign busy = !pipe_ready;

    // Drop zero values at the door: they produce no tokens
    rne_digit_pipe u_digit_pipe
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && (value != '0)),
        .in_value   (value),
        .in_ready   (pipe_ready),
        .out_valid  (digits_valid),
        .out_digits (digits),
        .out_take   (digits_take)
    );

    // Advance one token per cycle; take the next digit word as a run ends
    rne_token_seq u_token_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (digits_valid),
        .in_digits (digits),
        .in_take   (digits_take),
        .tok_valid (valid),
        .tok_code  (symbol_code),
        .tok_oor   (out_of_range),
        .tok_last  (last)
    );

endmodule
